>>> design/bfbs_pkg.sv
// Bloom filter bit store: shared types, field widths and operation codes.
// No dependencies; every other design file imports this package.
`default_nettype none

package bfbs_pkg;

	localparam int HASH_W     = 32;
	localparam int OPC_W      = 3;
	localparam int BIT_POS_W  = 5;
	localparam int DIV_W      = HASH_W - BIT_POS_W;
	localparam int FW_W       = 8;
	localparam int HC_W       = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	// Remainder unit: STEP_BITS dividend bits retired per cycle.
	localparam int STEP_BITS  = 4;
	localparam int MOD_STEPS  = (DIV_W + STEP_BITS - 1) / STEP_BITS;
	localparam int PAD_W      = MOD_STEPS * STEP_BITS;
	localparam int STEP_CNT_W = $clog2(MOD_STEPS);

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [OPC_W-1:0] OPC_SET   = 3'd0;
	localparam logic [OPC_W-1:0] OPC_CLR   = 3'd1;
	localparam logic [OPC_W-1:0] OPC_TEST  = 3'd2;
	localparam logic [OPC_W-1:0] OPC_ADD   = 3'd3;
	localparam logic [OPC_W-1:0] OPC_QUERY = 3'd4;
	localparam logic [OPC_W-1:0] OPC_WIPE  = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_WORDS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT   = 1'b1;

	localparam logic [FW_W-1:0] FW_RESET = 8'd128;
	localparam logic [HC_W-1:0] HC_RESET = 2'd2;

	typedef enum logic [2:0] {
		CMD_SET,
		CMD_CLR,
		CMD_TEST,
		CMD_QUERY,
		CMD_WIPE,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic              two;
		logic [HASH_W-1:0] h1;
		logic [HASH_W-1:0] h2;
	} cmd_t;

	typedef struct packed {
		logic init_busy;
	} bk_status_t;

	typedef enum logic [2:0] {
		BK_WIPE,
		BK_IDLE,
		BK_MOD,
		BK_UPDATE,
		BK_RESP
	} bk_state_t;

endpackage

`default_nettype wire

>>> design/bfbs_if.sv
// Bloom filter bit store: valid/ready channel interfaces for requests and responses.
// Depends on bfbs_pkg for field widths.
`default_nettype none

interface bfbs_in_if;
	import bfbs_pkg::*;

	logic              valid;
	logic              ready;
	logic [OPC_W-1:0]  opcode;
	logic [HASH_W-1:0] hash_first;
	logic [HASH_W-1:0] hash_second;

	modport source (output valid, output opcode, output hash_first, output hash_second,
		input ready);
	modport sink (input valid, input opcode, input hash_first, input hash_second,
		output ready);
endinterface

interface bfbs_out_if;
	logic valid;
	logic ready;
	logic found;

	modport source (output valid, output found, input ready);
	modport sink (input valid, input found, output ready);
endinterface

`default_nettype wire

>>> design/bfbs_front.sv
// Bloom filter bit store front end: accepts request items and classifies them
// into commands for the queue. Depends on bfbs_pkg and bfbs_if.
`default_nettype none

module bfbs_front (
	bfbs_in_if.sink              req,
	input  logic                 two_hashes,
	input  bfbs_pkg::bk_status_t status,
	input  logic                 q_full,
	output logic                 q_push,
	output bfbs_pkg::cmd_t       q_cmd
);
	import bfbs_pkg::*;

	always_comb begin
		req.ready = !q_full && !status.init_busy;
		q_push    = req.valid && req.ready;
		q_cmd.h1  = req.hash_first;
		q_cmd.h2  = req.hash_second;
		q_cmd.two = 1'b0;
		unique case (req.opcode)
			OPC_SET:   q_cmd.kind = CMD_SET;
			OPC_CLR:   q_cmd.kind = CMD_CLR;
			OPC_TEST:  q_cmd.kind = CMD_TEST;
			OPC_ADD: begin
				q_cmd.kind = CMD_SET;
				q_cmd.two  = two_hashes;
			end
			OPC_QUERY: begin
				q_cmd.kind = CMD_QUERY;
				q_cmd.two  = two_hashes;
			end
			OPC_WIPE:  q_cmd.kind = CMD_WIPE;
			default:   q_cmd.kind = CMD_NOP;
		endcase
	end

endmodule

`default_nettype wire

>>> design/bfbs_cmd_queue.sv
// Bloom filter bit store: two-entry command queue between front and back end.
// Depends on bfbs_pkg.
`default_nettype none

module bfbs_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bfbs_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output bfbs_pkg::cmd_t head
);
	import bfbs_pkg::*;

	cmd_t                   entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign full  = count_q == QUEUE_CNT_W'(QUEUE_DEPTH);
	assign valid = count_q != '0;
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

`default_nettype wire

>>> design/bfbs_word_mod.sv
// Bloom filter bit store: iterative remainder unit, reduces a word address
// modulo the filter size, STEP_BITS dividend bits per cycle. Depends on bfbs_pkg.
`default_nettype none

module bfbs_word_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [bfbs_pkg::DIV_W-1:0]  dividend,
	input  logic [bfbs_pkg::FW_W-1:0]   divisor,
	output logic                        done,
	output logic [bfbs_pkg::FW_W-1:0]   rem
);
	import bfbs_pkg::*;

	logic [PAD_W-1:0]      num_q;
	logic [FW_W-1:0]       div_q;
	logic [FW_W-1:0]       rem_q;
	logic [FW_W-1:0]       rem_nx;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;

	// Restoring steps: shift in one dividend bit, subtract when it fits.
	always_comb begin
		logic [FW_W:0] t;
		rem_nx = rem_q;
		for (int i = 0; i < STEP_BITS; i++) begin
			t = {rem_nx, num_q[PAD_W-1-i]};
			if (t >= {1'b0, div_q})
				rem_nx = FW_W'(t - {1'b0, div_q});
			else
				rem_nx = t[FW_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_CNT_W'(MOD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= PAD_W'(dividend);
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << STEP_BITS;
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

>>> design/bfbs_back.sv
// Bloom filter bit store back end: sequencer, bit memory with read-modify-write,
// clear sweep and response register. Depends on bfbs_pkg and bfbs_if.
`default_nettype none

module bfbs_back #(
	parameter int MAX_WORDS = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  bfbs_pkg::cmd_t              q_head,
	output logic                        q_pop,
	output logic                        mod_start,
	output logic [bfbs_pkg::DIV_W-1:0]  mod_dividend,
	input  logic                        mod_done,
	input  logic [bfbs_pkg::FW_W-1:0]   mod_rem,
	output bfbs_pkg::bk_status_t        status,
	bfbs_out_if.source                  rsp
);
	import bfbs_pkg::*;

	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam logic [AW-1:0] LAST_WORD = AW'(MAX_WORDS - 1);

	logic [HASH_W-1:0] mem [MAX_WORDS];

	bk_state_t         state_q, state_d;
	cmd_t              cmd_q;
	logic              second_q;
	logic              hit_q;
	logic [AW-1:0]     addr_q;
	logic [BIT_POS_W-1:0] bitpos_q;
	logic [HASH_W-1:0] rdata_q;
	logic [AW-1:0]     wipe_cnt_q;
	logic              wipe_rsp_q;
	logic              init_q;
	logic              rsp_valid_q;
	logic              found_q;

	logic [HASH_W-1:0]    cur_hash;
	logic [AW+FW_W-1:0]   rem_ext;
	logic [AW-1:0]        rem_addr;
	logic [HASH_W-1:0]    mask;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [HASH_W-1:0]    mem_wdata;
	logic                 mem_re;
	logic                 go_second;
	logic                 rsp_load;

	assign cur_hash = second_q ? cmd_q.h2 : cmd_q.h1;
	// Remainder is below the word count, so it always fits the address.
	assign rem_ext  = {{AW{1'b0}}, mod_rem};
	assign rem_addr = rem_ext[AW-1:0];
	assign mask     = HASH_W'(1) << bitpos_q;

	always_comb begin
		state_d      = state_q;
		q_pop        = 1'b0;
		mod_start    = 1'b0;
		mod_dividend = q_head.h1[HASH_W-1:BIT_POS_W];
		mem_we       = 1'b0;
		mem_waddr    = addr_q;
		mem_wdata    = rdata_q;
		mem_re       = 1'b0;
		go_second    = 1'b0;
		rsp_load     = 1'b0;
		unique case (state_q)
			BK_WIPE: begin
				mem_we    = 1'b1;
				mem_waddr = wipe_cnt_q;
				mem_wdata = '0;
				if (wipe_cnt_q == LAST_WORD)
					state_d = wipe_rsp_q ? BK_RESP : BK_IDLE;
			end
			BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (q_head.kind)
						CMD_WIPE: state_d = BK_WIPE;
						CMD_NOP:  state_d = BK_RESP;
						default: begin
							mod_start = 1'b1;
							state_d   = BK_MOD;
						end
					endcase
				end
			end
			BK_MOD: begin
				if (mod_done) begin
					mem_re  = 1'b1;
					state_d = BK_UPDATE;
				end
			end
			BK_UPDATE: begin
				if (cmd_q.kind == CMD_SET) begin
					mem_we    = 1'b1;
					mem_wdata = rdata_q | mask;
				end else if (cmd_q.kind == CMD_CLR) begin
					mem_we    = 1'b1;
					mem_wdata = rdata_q & ~mask;
				end
				if (!second_q && cmd_q.two) begin
					go_second    = 1'b1;
					mod_start    = 1'b1;
					mod_dividend = cmd_q.h2[HASH_W-1:BIT_POS_W];
					state_d      = BK_MOD;
				end else begin
					state_d = BK_RESP;
				end
			end
			BK_RESP: begin
				// Hold the result until the output register frees up.
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_WIPE;
			wipe_cnt_q  <= '0;
			wipe_rsp_q  <= 1'b0;
			init_q      <= 1'b1;
			second_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_WIPE) begin
				if (wipe_cnt_q == LAST_WORD) begin
					wipe_cnt_q <= '0;
					init_q     <= 1'b0;
				end else begin
					wipe_cnt_q <= wipe_cnt_q + 1'b1;
				end
			end
			if (q_pop) begin
				second_q   <= 1'b0;
				wipe_rsp_q <= q_head.kind == CMD_WIPE;
			end else if (go_second) begin
				second_q <= 1'b1;
			end
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head;
			hit_q <= q_head.kind == CMD_TEST || q_head.kind == CMD_QUERY;
		end else if (state_q == BK_UPDATE) begin
			hit_q <= hit_q & rdata_q[bitpos_q];
		end
		if (mem_re) begin
			addr_q   <= rem_addr;
			bitpos_q <= cur_hash[BIT_POS_W-1:0];
		end
		if (rsp_load)
			found_q <= hit_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rdata_q <= mem[rem_addr];
	end

	assign status.init_busy = init_q;
	assign rsp.valid        = rsp_valid_q;
	assign rsp.found        = found_q;

endmodule

`default_nettype wire

>>> design/bloom_filter_bit_store.sv
// Bloom filter bit store top level. Every accepted request gets a response, whether it
// uses one hash or two, clears all words, or carries one of the spare codes 6 and 7.
// One item at a time in the back-end sequencer: it pops the next item only after the last
// has loaded its response. Each hash goes through the 4-bit-per-cycle remainder unit and a
// word read-modify-write. After reset a clear pass over all MAX_WORDS words zeroes the
// memory; no request is accepted until it ends, configuration writes are taken throughout.
`default_nettype none

module bloom_filter_bit_store #(
	parameter int MAX_WORDS = 128
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	bfbs_in_if.sink                              req,
	bfbs_out_if.source                           rsp,
	input  logic                                 cfg_we,
	input  logic [bfbs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bfbs_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import bfbs_pkg::*;

	localparam int CMP_W = 17;
	localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_WORDS);

	logic [FW_W-1:0] filter_words_q;
	logic [HC_W-1:0] hash_count_q;
	logic [FW_W-1:0] words_use;

	bk_status_t       status;
	logic             q_push;
	cmd_t             q_cmd;
	logic             q_full;
	logic             q_pop;
	logic             q_valid;
	cmd_t             q_head;
	logic             mod_start;
	logic [DIV_W-1:0] mod_dividend;
	logic             mod_done;
	logic [FW_W-1:0]  mod_rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_words_q <= FW_RESET;
			hash_count_q   <= HC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FILTER_WORDS: filter_words_q <= cfg_data;
				CFG_HASH_COUNT:   hash_count_q   <= cfg_data[HC_W-1:0];
			endcase
		end
	end

	// Zero acts as one word; clamp to the memory depth.
	always_comb begin
		if (filter_words_q == '0)
			words_use = FW_W'(1);
		else if (CMP_W'(filter_words_q) > MAX_EXT)
			words_use = FW_W'(MAX_WORDS);
		else
			words_use = filter_words_q;
	end

	bfbs_front u_front (
		.req        (req),
		.two_hashes (hash_count_q[1]),
		.status     (status),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_cmd)
	);

	bfbs_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	bfbs_word_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dividend),
		.divisor  (words_use),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	bfbs_back #(
		.MAX_WORDS (MAX_WORDS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.mod_start    (mod_start),
		.mod_dividend (mod_dividend),
		.mod_done     (mod_done),
		.mod_rem      (mod_rem),
		.status       (status),
		.rsp          (rsp)
	);

endmodule

`default_nettype wire

>>> tb/sv/tb_bloom_filter_bit_store.sv
// Testbench for the Bloom filter bit store: directed and random set, clear, test,
// add, query and clear-all items over several size and hash-count settings.
// Depends on bfbs_pkg, the bfbs_in_if / bfbs_out_if channels and the block itself.
`timescale 1ns / 1ps

module tb_bloom_filter_bit_store;
	import bfbs_pkg::*;

	localparam int STORE_WORDS = 128;
	localparam logic [OPC_W-1:0] OPC_SPARE_LO = 3'd6;
	localparam logic [OPC_W-1:0] OPC_SPARE_HI = 3'd7;
	localparam int PHASES = 10;

	typedef struct {
		logic [OPC_W-1:0]  opcode;
		logic [HASH_W-1:0] h_first;
		logic [HASH_W-1:0] h_second;
	} req_item_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bfbs_in_if req_if ();
	bfbs_out_if rsp_if ();

	bloom_filter_bit_store #(.MAX_WORDS(STORE_WORDS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Own copy of the bit store and its registers
	logic [31:0] filter_model [0:STORE_WORDS-1];
	logic [FW_W-1:0] model_words;
	logic [HC_W-1:0] model_hashes;

	req_item_t pending_items[$];
	bit found_expected[$];
	logic [HASH_W-1:0] hash_pool [0:15];

	int error_count = 0;
	int results_seen = 0;
	bit item_taken = 0;
	bit calm = 0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit long_hold_done = 0;

	always #2 clk = ~clk;

	function automatic logic [11:0] bit_address(input logic [HASH_W-1:0] h);
		logic [31:0] words;
		logic [31:0] modulus;
		words = 32'(model_words);
		if (words == 0)
			words = 1;
		if (words > STORE_WORDS)
			words = STORE_WORDS;
		modulus = words * 32;
		return 12'(h % modulus);
	endfunction

	function automatic bit bit_is_set(input logic [HASH_W-1:0] h);
		logic [11:0] a;
		a = bit_address(h);
		return filter_model[a[11:5]][a[4:0]];
	endfunction

	function automatic void write_bit(input logic [HASH_W-1:0] h, input logic value);
		logic [11:0] a;
		a = bit_address(h);
		filter_model[a[11:5]][a[4:0]] = value;
	endfunction

	// Apply one item to the model store and return the expected found flag
	function automatic bit apply_filter_op(input req_item_t it);
		bit two;
		bit hit;
		two = (model_hashes == 2'd0 || model_hashes == 2'd1) ? 1'b0 : 1'b1;
		hit = 1'b0;
		case (it.opcode)
			OPC_SET: write_bit(it.h_first, 1'b1);
			OPC_CLR: write_bit(it.h_first, 1'b0);
			OPC_TEST: hit = bit_is_set(it.h_first);
			OPC_ADD: begin
				write_bit(it.h_first, 1'b1);
				if (two)
					write_bit(it.h_second, 1'b1);
			end
			OPC_QUERY: begin
				hit = bit_is_set(it.h_first);
				if (two && !bit_is_set(it.h_second))
					hit = 1'b0;
			end
			OPC_WIPE: begin
				for (int i = 0; i < STORE_WORDS; i++)
					filter_model[i] = '0;
			end
			default: ;
		endcase
		return hit;
	endfunction

	function automatic logic [HASH_W-1:0] pick_hash();
		logic [HASH_W-1:0] h;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5) begin
			h = hash_pool[$urandom_range(0, 15)];
		end else begin
			if (sel < 7)
				h = $urandom_range(0, 300);
			else if (sel == 7)
				h = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			else
				h = $urandom;
			hash_pool[$urandom_range(0, 15)] = h;
		end
		return h;
	endfunction

	// Accepted items feed the model; accepted results are checked in order
	always @(posedge clk) begin
		req_item_t it;
		bit want;
		item_taken = arst_n && req_if.valid && req_if.ready;
		if (item_taken) begin
			it.opcode = req_if.opcode;
			it.h_first = req_if.hash_first;
			it.h_second = req_if.hash_second;
			found_expected.push_back(apply_filter_op(it));
		end
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			results_seen++;
			if (found_expected.size() == 0) begin
				$error("found: unexpected result, actual %0b", rsp_if.found);
				error_count++;
			end else begin
				want = found_expected.pop_front();
				if (rsp_if.found !== want) begin
					$error("found: expected %0b, actual %0b", want, rsp_if.found);
					error_count++;
				end
			end
		end
	end

	// Item driver
	always @(negedge clk) begin
		req_item_t it;
		if (!req_if.valid || item_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				req_if.valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				it = pending_items.pop_front();
				req_if.opcode <= it.opcode;
				req_if.hash_first <= it.h_first;
				req_if.hash_second <= it.h_second;
				req_if.valid <= 1'b1;
				if (!calm && $urandom_range(0, 4) == 0)
					send_gap = $urandom_range(1, 7);
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls plus one long hold-off to back up the block
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			rsp_if.ready <= 1'b0;
		end else if (!long_hold_done && results_seen >= 120) begin
			long_hold_done = 1;
			hold_left = 400;
			rsp_if.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_if.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 7) - 1;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	task automatic queue_item(input logic [OPC_W-1:0] op, input logic [HASH_W-1:0] h1,
		input logic [HASH_W-1:0] h2);
		req_item_t it;
		it.opcode = op;
		it.h_first = h1;
		it.h_second = h2;
		pending_items.push_back(it);
	endtask

	// Hold until every queued item is sent and every result has come back
	task automatic drain();
		while (pending_items.size() != 0 || req_if.valid || found_expected.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == CFG_FILTER_WORDS)
			model_words = value;
		else
			model_hashes = value[HC_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_size(input logic [FW_W-1:0] words, input logic [HC_W-1:0] hashes);
		logic [5:0] junk;
		junk = 6'($urandom);
		write_reg(CFG_FILTER_WORDS, words);
		write_reg(CFG_HASH_COUNT, {junk, hashes});
	endtask

	task automatic run_random(input int count);
		int r;
		logic [OPC_W-1:0] op;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 14)
				op = OPC_SET;
			else if (r < 22)
				op = OPC_CLR;
			else if (r < 40)
				op = OPC_TEST;
			else if (r < 60)
				op = OPC_ADD;
			else if (r < 88)
				op = OPC_QUERY;
			else if (r < 90)
				op = OPC_WIPE;
			else if (r < 95)
				op = $urandom_range(0, 1) ? OPC_SPARE_HI : OPC_SPARE_LO;
			else
				op = OPC_W'($urandom_range(0, 7));
			queue_item(op, pick_hash(), pick_hash());
		end
		drain();
	endtask

	initial begin
		logic [FW_W-1:0] phase_words [PHASES];
		logic [HC_W-1:0] phase_hashes [PHASES];

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_if.valid = 1'b0;
		req_if.opcode = '0;
		req_if.hash_first = '0;
		req_if.hash_second = '0;
		rsp_if.ready = 1'b0;
		for (int i = 0; i < STORE_WORDS; i++)
			filter_model[i] = '0;
		for (int i = 0; i < 16; i++)
			hash_pool[i] = $urandom;
		model_words = FW_RESET;
		model_hashes = HC_RESET;

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Directed: reset sizes, extremes, every opcode
		queue_item(OPC_TEST, 32'h0, 32'h0);
		queue_item(OPC_SET, 32'h0, 32'hFFFF_FFFF);
		queue_item(OPC_TEST, 32'h0, 32'h0);
		queue_item(OPC_SET, 32'hFFFF_FFFF, 32'h0);
		queue_item(OPC_TEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_item(OPC_ADD, 32'h1234_5678, 32'h8765_4321);
		queue_item(OPC_QUERY, 32'h1234_5678, 32'h8765_4321);
		queue_item(OPC_QUERY, 32'h0, 32'h5);
		queue_item(OPC_CLR, 32'h0, 32'h0);
		queue_item(OPC_TEST, 32'h0, 32'h0);
		queue_item(OPC_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_item(OPC_SPARE_HI, 32'h1234_5678, 32'h8765_4321);
		queue_item(OPC_WIPE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_item(OPC_QUERY, 32'h1234_5678, 32'h8765_4321);
		drain();

		// One word, hash count zero acts as one
		set_size(8'd1, 2'd0);
		queue_item(OPC_ADD, 32'd33, 32'd7);
		queue_item(OPC_QUERY, 32'd1, 32'd7);
		queue_item(OPC_TEST, 32'd7, 32'd0);
		queue_item(OPC_SET, 32'd2, 32'd0);
		drain();

		// Oversized word count, hash count three; resizing keeps bits
		set_size(8'd255, 2'd3);
		queue_item(OPC_TEST, 32'd2, 32'd0);
		queue_item(OPC_QUERY, 32'd2, 32'hFFFF_FFFF);
		queue_item(OPC_SET, 32'hFFFF_FFFF, 32'd0);
		drain();

		// Clear all reaches past the words in use
		set_size(8'd0, 2'd1);
		queue_item(OPC_WIPE, 32'd0, 32'd0);
		drain();
		set_size(8'd128, 2'd2);
		queue_item(OPC_TEST, 32'hFFFF_FFFF, 32'd0);
		drain();

		phase_words = '{8'd128, 8'd1, 8'd255, 8'd0, 8'd7, 8'd64, 8'd0, 8'd200, 8'd3, 8'd128};
		phase_hashes = '{2'd2, 2'd1, 2'd3, 2'd0, 2'd2, 2'd1, 2'd0, 2'd2, 2'd3, 2'd2};
		phase_words[6] = FW_W'($urandom_range(1, 128));
		phase_hashes[6] = HC_W'($urandom_range(0, 3));
		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1)
				calm = 1;
			set_size(phase_words[p], phase_hashes[p]);
			run_random(150);
		end

		repeat (200) @(posedge clk);
		if (error_count == 0 && found_expected.size() == 0)
			$display("tb_bloom_filter_bit_store: clean");
		else
			$display("tb_bloom_filter_bit_store: errors");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("tb_bloom_filter_bit_store: errors");
		$finish;
	end

endmodule

>>> files.f
design/bfbs_pkg.sv
design/bfbs_if.sv
design/bfbs_front.sv
design/bfbs_cmd_queue.sv
design/bfbs_word_mod.sv
design/bfbs_back.sv
design/bloom_filter_bit_store.sv
tb/sv/tb_bloom_filter_bit_store.sv
